/* design/fsk_pkg.sv */
// Shared types, constants and codes of the FSK frame transmitter.
package fsk_pkg;

	// Frame buffer geometry
	localparam int BUF_BYTES  = 256;
	localparam int CNT_W      = $clog2(BUF_BYTES + 1);
	localparam int ADDR_W     = $clog2(BUF_BYTES);
	localparam int POS_W      = ADDR_W + 3;
	localparam int CMP_W      = POS_W + 1;

	// Register and counter widths
	localparam int HALF_W     = 16;
	localparam int BIT_W      = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HI_HALF  = 2'd0,
		REG_LO_HALF  = 2'd1,
		REG_SYNC_PER = 2'd2,
		REG_DATA_PER = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_LOAD = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SYNC_HI,
		ST_SYNC_LO,
		ST_GAP,
		ST_DATA,
		ST_FETCH
	} state_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic       last_byte;
	} fsk_in_t;

	typedef struct packed {
		logic tx_level;
		logic tx_enable;
		logic busy_res;
		logic frame_done;
	} fsk_out_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic start;
		logic carrier;
		logic bit_adv;
		logic sync_hi;
		logic data_per;
		logic gap_to_data;
		logic pos_adv;
		logic finish;
		logic fetch;
		logic carrier_on;
		logic out_load;
		logic out_enable;
		logic out_busy;
		logic out_done;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic bit_end;
		logic buf_empty;
		logic frame_end;
		logic byte_cross;
	} status_t;

endpackage

/* design/fsk_ctrl.sv */
// Frame sequencer: phase state machine, handshakes and datapath commands.
module fsk_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fsk_pkg::fsk_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	input  fsk_pkg::status_t  status,
	output fsk_pkg::cmd_t     cmd
);
	import fsk_pkg::*;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   accept;
	logic   is_tick;
	logic   is_load;

	// Take a transaction when not fetching and the output register can move
	assign in_ready  = (state_q != ST_FETCH) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign is_tick   = accept && (in_data.kind == KIND_TICK);
	assign is_load   = accept && (in_data.kind == KIND_LOAD);
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (is_load && in_data.last_byte) state_nx = ST_SYNC_HI;
			end
			ST_SYNC_HI: begin
				if (is_tick && status.bit_end) state_nx = ST_SYNC_LO;
			end
			ST_SYNC_LO: begin
				if (is_tick && status.bit_end) state_nx = ST_GAP;
			end
			ST_GAP: begin
				if (is_tick) state_nx = status.buf_empty ? ST_IDLE : ST_FETCH;
			end
			ST_DATA: begin
				if (is_tick && status.bit_end) begin
					if (status.frame_end) state_nx = ST_IDLE;
					else if (status.byte_cross) state_nx = ST_FETCH;
				end
			end
			ST_FETCH: state_nx = ST_DATA;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// Commands and result flags
	always_comb begin
		cmd            = '0;
		cmd.carrier_on = (state_q == ST_SYNC_HI) || (state_q == ST_SYNC_LO) ||
		                 (state_q == ST_DATA);
		cmd.sync_hi    = (state_q == ST_SYNC_HI);
		cmd.data_per   = (state_q == ST_DATA);
		cmd.out_load   = accept;
		cmd.out_enable = cmd.carrier_on;
		case (state_q)
			ST_IDLE: begin
				cmd.load     = is_load;
				cmd.start    = is_load && in_data.last_byte;
				cmd.out_busy = is_load && in_data.last_byte;
			end
			ST_SYNC_HI, ST_SYNC_LO: begin
				cmd.out_busy = 1'b1;
				cmd.carrier  = is_tick;
				cmd.bit_adv  = is_tick;
			end
			ST_GAP: begin
				cmd.out_busy    = 1'b1;
				cmd.finish      = is_tick && status.buf_empty;
				cmd.out_done    = is_tick && status.buf_empty;
				cmd.gap_to_data = is_tick && !status.buf_empty;
			end
			ST_DATA: begin
				cmd.out_busy = 1'b1;
				cmd.carrier  = is_tick;
				cmd.bit_adv  = is_tick;
				cmd.finish   = is_tick && status.bit_end && status.frame_end;
				cmd.out_done = is_tick && status.bit_end && status.frame_end;
				cmd.pos_adv  = is_tick && status.bit_end && !status.frame_end;
			end
			ST_FETCH: begin
				cmd.out_busy = 1'b1;
				cmd.fetch    = 1'b1;
			end
			default: begin
				cmd.finish = 1'b1;
			end
		endcase
	end

	// Hold state and output-register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

/* design/fsk_datapath.sv */
// Datapath: registers, frame buffer memory, carrier and bit counters, result register.
module fsk_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [fsk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fsk_pkg::CFG_DATA_W-1:0] cfg_data,
	input  fsk_pkg::fsk_in_t              in_data,
	input  fsk_pkg::cmd_t                 cmd,
	output fsk_pkg::status_t              status,
	output fsk_pkg::fsk_out_t             out_data
);
	import fsk_pkg::*;

	logic [HALF_W-1:0] hi_half_q;
	logic [HALF_W-1:0] lo_half_q;
	logic [BIT_W-1:0]  sync_per_q;
	logic [BIT_W-1:0]  data_per_q;

	logic [7:0]        mem [BUF_BYTES];
	logic [7:0]        rd_byte_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [POS_W-1:0]  pos_q;
	logic [HALF_W-1:0] half_q;
	logic [BIT_W-1:0]  bc_q;
	logic              level_q;
	fsk_out_t          out_q;

	logic              buf_full;
	logic              use_hi;
	logic [HALF_W-1:0] half_per;
	logic [HALF_W-1:0] half_nx;
	logic              half_wrap;
	logic [BIT_W-1:0]  bit_per;
	logic [BIT_W-1:0]  bc_nx;
	logic [CMP_W-1:0]  pos_inc;
	logic [CMP_W-1:0]  frame_lim;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_half_q  <= HALF_W'(12);
			lo_half_q  <= HALF_W'(15);
			sync_per_q <= BIT_W'(1000);
			data_per_q <= BIT_W'(500);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_HI_HALF:  hi_half_q  <= cfg_data[HALF_W-1:0];
				REG_LO_HALF:  lo_half_q  <= cfg_data[HALF_W-1:0];
				REG_SYNC_PER: sync_per_q <= cfg_data[BIT_W-1:0];
				REG_DATA_PER: data_per_q <= cfg_data[BIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Carrier frequency select: high in first sync bit, buffer bit during data
	assign use_hi    = cmd.sync_hi || (cmd.data_per && rd_byte_q[pos_q[2:0]]);
	assign half_per  = use_hi ? hi_half_q : lo_half_q;
	assign half_nx   = half_q + HALF_W'(1);
	assign half_wrap = (half_nx >= half_per) || (half_nx == '0);

	// Bit period end, a zero period acts as one tick
	assign bit_per   = cmd.data_per ? data_per_q : sync_per_q;
	assign bc_nx     = bc_q + BIT_W'(1);
	assign buf_full  = (cnt_q >= CNT_W'(BUF_BYTES));

	assign pos_inc   = {1'b0, pos_q} + CMP_W'(1);
	assign frame_lim = CMP_W'({cnt_q, 3'b000});

	assign status.bit_end    = (bc_nx >= bit_per) || (bc_nx == '0);
	assign status.buf_empty  = (cnt_q == '0);
	assign status.frame_end  = (pos_inc >= frame_lim);
	assign status.byte_cross = (pos_q[2:0] == 3'b111);

	// Frame buffer: append on load, fetch the current data byte
	always_ff @(posedge clk) begin
		if (cmd.load && !buf_full) mem[cnt_q[ADDR_W-1:0]] <= in_data.data_byte;
		if (cmd.fetch) rd_byte_q <= mem[pos_q[POS_W-1:3]];
	end

	// Advance counters and carrier level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			pos_q   <= '0;
			half_q  <= '0;
			bc_q    <= '0;
			level_q <= 1'b0;
		end else if (cmd.finish) begin
			cnt_q   <= '0;
			pos_q   <= '0;
			half_q  <= '0;
			bc_q    <= '0;
			level_q <= 1'b0;
		end else begin
			if (cmd.load && !buf_full) cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.start || cmd.gap_to_data) begin
				pos_q   <= '0;
				half_q  <= '0;
				bc_q    <= '0;
				level_q <= 1'b0;
			end else begin
				if (cmd.carrier) begin
					half_q <= half_wrap ? '0 : half_nx;
					if (half_wrap) level_q <= ~level_q;
				end
				if (cmd.bit_adv) bc_q <= status.bit_end ? '0 : bc_nx;
				if (cmd.pos_adv) pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	// Capture the result of each accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.tx_level   <= cmd.carrier_on && level_q;
			out_q.tx_enable  <= cmd.out_enable;
			out_q.busy_res   <= cmd.out_busy;
			out_q.frame_done <= cmd.out_done;
		end
	end

	assign out_data = out_q;

endmodule

/* design/fsk_frame_transmitter.sv */
// Top level of the FSK frame transmitter: sequencer plus datapath.
//
//   channel  signals                           direction  content
//   in       in_valid/in_ready/in_data         input      kind, data_byte, last_byte
//   out      out_valid/out_ready/out_data      output     tx_level, tx_enable, busy_res,
//                                                         frame_done
//   cfg      cfg_valid/cfg_ready/cfg_index/    input      register index 0..3, value
//            cfg_data
//
// One result per input transaction, one transaction per cycle while in_ready
// is high. A tick that ends the gap into data, or a data bit at a byte boundary,
// passes through the fetch state, in which in_ready is low while the next byte
// is read from the buffer memory. The result register lets the next transaction
// in while a result waits; with out_ready low and the result register full,
// in_ready drops. Reset is asynchronous; the buffer memory is not cleared.
// cfg_ready is always high.
module fsk_frame_transmitter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  fsk_pkg::fsk_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output fsk_pkg::fsk_out_t             out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fsk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fsk_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fsk_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	fsk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	fsk_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

/* design/fsk_checker.sv */
// Port-level checker for the FSK frame transmitter and its bind.
module fsk_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input fsk_pkg::fsk_out_t out_data
);
	import fsk_pkg::*;

	// A finishing tick still reports the frame as busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_done |-> out_data.busy_res)
		else $error("frame_done without busy_res");

	// The transmitter is enabled only inside a frame
	a_enable_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tx_enable |-> out_data.busy_res)
		else $error("tx_enable outside a frame");

	// The carrier pin stays low while disabled
	a_level_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.tx_enable |-> !out_data.tx_level)
		else $error("tx_level high with tx_enable low");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

endmodule

bind fsk_frame_transmitter fsk_checker u_fsk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

/* test/fsk_frame_checker.sv */
`timescale 1ns / 1ps
// Monitor for the FSK frame transmitter: predicts pin results per transaction and compares.
module fsk_frame_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  fsk_pkg::fsk_in_t               in_data,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  fsk_pkg::fsk_out_t              out_data,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [fsk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fsk_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             fails,
	output int                             backlog
);
	import fsk_pkg::*;

	// Shadow copy of the transmitter state
	logic [7:0]        frame_mem [BUF_BYTES];
	logic [CNT_W-1:0]  bytes_held;
	logic [CMP_W-1:0]  bit_idx;
	state_t            tx_phase;
	logic [HALF_W-1:0] half_cnt;
	logic [BIT_W-1:0]  bit_cnt;
	logic              carrier_lvl;
	logic              tone_hi;

	// Shadow copy of the timing registers
	logic [HALF_W-1:0] hi_half;
	logic [HALF_W-1:0] lo_half;
	logic [BIT_W-1:0]  sync_len;
	logic [BIT_W-1:0]  data_len;

	// Pin results still owed by the block, oldest first
	fsk_out_t pins_owed [$];

	// Drop back to idle with pins low
	task end_frame;
		tx_phase    = ST_IDLE;
		carrier_lvl = 1'b0;
		half_cnt    = '0;
		bit_cnt     = '0;
		bit_idx     = '0;
		bytes_held  = '0;
		tone_hi     = 1'b0;
	endtask

	// Advance the carrier by one tick, toggling at the end of a half period
	task step_carrier;
		logic [HALF_W-1:0] lim;
		lim      = tone_hi ? hi_half : lo_half;
		half_cnt = half_cnt + 1'b1;
		if (half_cnt >= lim || half_cnt == '0) begin
			carrier_lvl = ~carrier_lvl;
			half_cnt    = '0;
		end
	endtask

	// Count one tick of the current bit; report whether the bit is over
	task step_bit(input logic [BIT_W-1:0] lim, output logic ended);
		bit_cnt = bit_cnt + 1'b1;
		ended   = (bit_cnt >= lim || bit_cnt == '0);
		if (ended)
			bit_cnt = '0;
	endtask

	// Work out the pins for one input transaction and update the shadow state
	task predict_pins(input fsk_in_t item, output fsk_out_t res);
		logic carrier_on;
		logic ended;
		carrier_on = (tx_phase == ST_SYNC_HI || tx_phase == ST_SYNC_LO || tx_phase == ST_DATA);
		res.tx_level   = carrier_on & carrier_lvl;
		res.tx_enable  = carrier_on;
		res.frame_done = 1'b0;
		if (item.kind == KIND_LOAD) begin
			// Append while idle; bytes past the buffer end are dropped
			if (tx_phase == ST_IDLE) begin
				if (bytes_held < BUF_BYTES) begin
					frame_mem[bytes_held[ADDR_W-1:0]] = item.data_byte;
					bytes_held = bytes_held + 1'b1;
				end
				if (item.last_byte) begin
					tx_phase    = ST_SYNC_HI;
					carrier_lvl = 1'b0;
					half_cnt    = '0;
					bit_cnt     = '0;
					bit_idx     = '0;
					tone_hi     = 1'b1;
				end
			end
			res.busy_res = (tx_phase != ST_IDLE);
		end else begin
			res.busy_res = (tx_phase != ST_IDLE);
			case (tx_phase)
				ST_SYNC_HI: begin
					step_carrier();
					step_bit(sync_len, ended);
					if (ended) begin
						tx_phase = ST_SYNC_LO;
						tone_hi  = 1'b0;
					end
				end
				ST_SYNC_LO: begin
					step_carrier();
					step_bit(sync_len, ended);
					if (ended) begin
						tx_phase    = ST_GAP;
						carrier_lvl = 1'b0;
					end
				end
				ST_GAP: begin
					if (bytes_held == '0) begin
						end_frame();
						res.frame_done = 1'b1;
					end else begin
						tx_phase    = ST_DATA;
						bit_idx     = '0;
						bit_cnt     = '0;
						half_cnt    = '0;
						carrier_lvl = 1'b0;
						tone_hi     = frame_mem[0][0];
					end
				end
				ST_DATA: begin
					step_carrier();
					step_bit(data_len, ended);
					if (ended) begin
						bit_idx = bit_idx + 1'b1;
						if (bit_idx >= {bytes_held, 3'b000}) begin
							end_frame();
							res.frame_done = 1'b1;
						end else begin
							tone_hi = frame_mem[bit_idx[ADDR_W+2:3]][bit_idx[2:0]];
						end
					end
				end
				default: ;
			endcase
		end
	endtask

	task check_pin(input string pin, input logic want, input logic got, inout int errs);
		if (got !== want) begin
			$error("%s: expected %0b, got %0b", pin, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		fsk_out_t want;
		int       errs;
		if (!arst_n) begin
			end_frame();
			hi_half  = 16'd12;
			lo_half  = 16'd15;
			sync_len = 24'd1000;
			data_len = 24'd500;
			pins_owed.delete();
			fails   <= 0;
			backlog <= 0;
		end else begin
			errs = 0;
			// Register writes are to be made only while the block is idle; neither the block nor this model enforces it
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_HI_HALF:  hi_half  = cfg_data[HALF_W-1:0];
					REG_LO_HALF:  lo_half  = cfg_data[HALF_W-1:0];
					REG_SYNC_PER: sync_len = cfg_data[BIT_W-1:0];
					REG_DATA_PER: data_len = cfg_data[BIT_W-1:0];
					default: ;
				endcase
			end
			// Compare a delivered result with the oldest one owed
			if (out_valid && out_ready) begin
				if (pins_owed.size() == 0) begin
					$error("result %b arrived with none owed", out_data);
					errs++;
				end else begin
					want = pins_owed.pop_front();
					check_pin("tx_level", want.tx_level, out_data.tx_level, errs);
					check_pin("tx_enable", want.tx_enable, out_data.tx_enable, errs);
					check_pin("busy_res", want.busy_res, out_data.busy_res, errs);
					check_pin("frame_done", want.frame_done, out_data.frame_done, errs);
				end
			end
			// Predict after comparing so a fresh transaction never meets its own result
			if (in_valid && in_ready) begin
				predict_pins(in_data, want);
				pins_owed.push_back(want);
			end
			fails   <= fails + errs;
			backlog <= pins_owed.size();
		end
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the FSK frame transmitter: clock, reset, stimulus and verdict.
module tb;
	import fsk_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 750;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	fsk_in_t               in_data   = '0;
	logic                  out_ready = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_ready;
	logic                  out_valid;
	fsk_out_t              out_data;
	logic                  cfg_ready;
	int                    fails;
	int                    backlog;

	bit          calm        = 1'b0;
	int          hold_left   = 0;
	int          idle_cycles = 0;
	int          items       = 0;
	int          frames      = 0;
	int          settings    = 0;
	int unsigned stray_bytes = 0;
	int unsigned sync_ticks  = 0;
	int unsigned data_ticks  = 0;

	fsk_frame_transmitter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fsk_frame_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.backlog   (backlog)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the result side in random bursts unless calm
	always @(negedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			hold_left <= $urandom_range(0, 6);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// End the run if no transaction moves on any channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Offer one input transaction, possibly after a burst of idle cycles
	task put(input kind_t kind, input logic [7:0] b, input logic last, input bit counts);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 7);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= fsk_in_t'({kind, b, last});
		do @(posedge clk); while (!in_ready);
		if (counts)
			items++;
	endtask

	task tick;
		put(KIND_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
	endtask

	// Load a byte that stays in the buffer for the next frame
	task stray_load;
		put(KIND_LOAD, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
		stray_bytes++;
	endtask

	task write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Hold input off until every owed result has been delivered
	task settle;
		@(negedge clk);
		in_valid <= 1'b0;
		do @(posedge clk); while (backlog != 0);
	endtask

	task set_timing(input int unsigned hi, input int unsigned lo, input int unsigned s,
			input int unsigned d);
		settle();
		write_reg(REG_HI_HALF, CFG_DATA_W'(hi));
		write_reg(REG_LO_HALF, CFG_DATA_W'(lo));
		write_reg(REG_SYNC_PER, CFG_DATA_W'(s));
		write_reg(REG_DATA_PER, CFG_DATA_W'(d));
		sync_ticks = s;
		data_ticks = d;
		settings++;
	endtask

	// Load a frame and clock it out to its final tick, with ignored loads mixed in
	task send_frame(input int nbytes, input bit noise);
		int unsigned held;
		int unsigned ticks;
		for (int i = 0; i < nbytes; i++) begin
			if ($urandom_range(0, 5) == 0)
				tick();
			put(KIND_LOAD, 8'($urandom_range(0, 255)), i == nbytes - 1, 1'b1);
		end
		held = stray_bytes + nbytes;
		if (held > BUF_BYTES)
			held = BUF_BYTES;
		stray_bytes = 0;
		ticks = 2 * sync_ticks + 1 + 8 * held * data_ticks;
		repeat (ticks) begin
			if (noise && $urandom_range(0, 9) == 0)
				put(KIND_LOAD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
			tick();
		end
		frames++;
	endtask

	function automatic int frame_bytes();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
	endfunction

	// Frames with occasional idle-time loads until the item budget is used up
	task run_phase(input int budget);
		int stop;
		stop = items + budget;
		while (items < stop) begin
			if ($urandom_range(0, 3) == 0)
				stray_load();
			if ($urandom_range(0, 3) == 0)
				tick();
			send_frame(frame_bytes(), 1'b1);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Registers at their upper limits, block left idle
		set_timing(16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF);
		put(KIND_TICK, 8'hFF, 1'b1, 1'b1);
		put(KIND_TICK, 8'h00, 1'b0, 1'b1);

		// Short frame: all-zero and all-ones bytes, then one random closing byte
		set_timing(1, 2, 1, 1);
		put(KIND_LOAD, 8'h00, 1'b0, 1'b1);
		stray_bytes++;
		put(KIND_LOAD, 8'hFF, 1'b0, 1'b1);
		stray_bytes++;
		send_frame(1, 1'b1);

		// Half periods too long to toggle, then everything at its minimum
		set_timing(16'hFFFF, 16'hFFFF, 1, 1);
		run_phase(60);
		set_timing(1, 1, 1, 1);
		run_phase(60);

		// Random timing settings
		while (items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0)
				set_timing($urandom_range(1, 300), $urandom_range(1, 300),
					$urandom_range(1, 8), $urandom_range(1, 5));
			else
				set_timing($urandom_range(1, 6), $urandom_range(1, 6),
					$urandom_range(1, 8), $urandom_range(1, 5));
			run_phase(100);
		end

		// Overfill the buffer; the extra bytes are dropped
		set_timing($urandom_range(1, 3), $urandom_range(1, 3), 1, 1);
		send_frame(BUF_BYTES + 2, 1'b1);

		// Closing stretch with no idling on either side
		calm = 1'b1;
		set_timing(2, 3, 2, 1);
		send_frame(2, 1'b1);
		send_frame(1, 1'b1);

		settle();
		repeat (8) @(posedge clk);
		$display("tb: %0d frames over %0d timing settings, %0d transactions", frames, settings,
			items);
		$display("tb: covered sync, gap, data, busy loads and a %0d-byte buffer overflow",
			BUF_BYTES);
		if (fails == 0 && backlog == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
